FILE: rtl/vvp_pkg.sv
package vvp_pkg;

    localparam int VERT_W  = 16;
    localparam int OUT_W   = 20;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 12;
    localparam int NEAR_W  = 16;
    localparam int COEF_W  = 16;

    // scale = min(w, h) / 2
    localparam int S_W     = DIM_W - 1;
    localparam int P_W     = VERT_W + S_W + 1;
    localparam int PROD_W  = COEF_W + P_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int FRAC_SH = 24;
    localparam int V_W     = ACC_W - FRAC_SH;
    localparam int MAG_W   = V_W;
    localparam int NUM_W   = MAG_W + NEAR_W + 1;
    localparam int DEN_W   = V_W - 1;
    localparam int RES_W   = NUM_W + 2;

    localparam logic [IDX_W-1:0] IDX_ROW_X  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_ROW_Y  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_ROW_Z  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_HEIGHT = 3'd4;
    localparam logic [IDX_W-1:0] IDX_NEAR   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_PERSP  = 3'd6;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd600;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd400;
    localparam logic [NEAR_W-1:0] RST_NEAR   = 16'd16;

    typedef struct packed {
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
        logic                  neg_x;
        logic                  neg_y;
        logic                  div_en;
        logic                  bad;
    } side_t;

endpackage

FILE: rtl/vertex_view_projection_transform.sv
// Stages from input transaction to result: 4 affine stages, 1 divide set-up
// stage, 40 divider stages, 1 output register.
// Throughput: one vertex per cycle unless stalled; the 40-stage restoring divider
// takes one quotient bit per stage, so a new transaction enters every unstalled cycle.
// A stalled valid output freezes the whole pipeline; in_stall follows it.
// Reset (rst_n low, asynchronous) clears all valid bits and loads register defaults.
module vertex_view_projection_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [vvp_pkg::VERT_W-1:0]    vert_x,
    input  logic signed [vvp_pkg::VERT_W-1:0]    vert_y,
    input  logic signed [vvp_pkg::VERT_W-1:0]    vert_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vvp_pkg::OUT_W-1:0]     screen_x,
    output logic signed [vvp_pkg::OUT_W-1:0]     screen_y,
    output logic signed [vvp_pkg::OUT_W-1:0]     view_depth,
    output logic                                 depth_invalid,
    input  logic                                 cfg_we,
    input  logic [vvp_pkg::IDX_W-1:0]            cfg_index,
    input  logic [vvp_pkg::CFG_W-1:0]            cfg_data
);

    logic [vvp_pkg::CFG_W-1:0]   row_x_reg, row_y_reg, row_z_reg;
    logic [vvp_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [vvp_pkg::NEAR_W-1:0]  near_reg;
    logic                        persp_reg;

    logic                        adv;
    logic [vvp_pkg::DIM_W-1:0]   min_dim;
    logic [vvp_pkg::S_W-1:0]     scale;

    logic                        v_valid;
    logic signed [vvp_pkg::V_W-1:0] vx, vy, vz;

    logic                        e_valid_reg;
    logic [vvp_pkg::NUM_W-1:0]   e_numx_reg, e_numy_reg, e_numx_next, e_numy_next;
    logic [vvp_pkg::DEN_W-1:0]   e_den_reg, e_den_next;
    vvp_pkg::side_t              e_side_reg, e_side_next;
    logic [vvp_pkg::MAG_W-1:0]   mag_x, mag_y;
    logic                        z_pos;

    logic                        q_valid;
    logic [vvp_pkg::NUM_W-1:0]   q_x, q_y;
    vvp_pkg::side_t              q_side;

    logic signed [vvp_pkg::RES_W-1:0] rx, ry, rz;
    logic                        out_valid_reg;
    logic signed [vvp_pkg::OUT_W-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic                        bad_reg;

    function automatic logic signed [vvp_pkg::OUT_W-1:0] sat(
        input logic signed [vvp_pkg::RES_W-1:0] v);
        logic signed [vvp_pkg::RES_W-1:0] hi;
        logic signed [vvp_pkg::RES_W-1:0] lo;
        hi = vvp_pkg::RES_W'((1 <<< (vvp_pkg::OUT_W - 1)) - 1);
        lo = -(vvp_pkg::RES_W'(1) <<< (vvp_pkg::OUT_W - 1));
        if (v > hi)
            return hi[vvp_pkg::OUT_W-1:0];
        else if (v < lo)
            return lo[vvp_pkg::OUT_W-1:0];
        else
            return v[vvp_pkg::OUT_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= '0;
            row_y_reg  <= '0;
            row_z_reg  <= '0;
            width_reg  <= vvp_pkg::RST_WIDTH;
            height_reg <= vvp_pkg::RST_HEIGHT;
            near_reg   <= vvp_pkg::RST_NEAR;
            persp_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vvp_pkg::IDX_ROW_X:  row_x_reg  <= cfg_data;
                vvp_pkg::IDX_ROW_Y:  row_y_reg  <= cfg_data;
                vvp_pkg::IDX_ROW_Z:  row_z_reg  <= cfg_data;
                vvp_pkg::IDX_WIDTH:  width_reg  <= cfg_data[vvp_pkg::DIM_W-1:0];
                vvp_pkg::IDX_HEIGHT: height_reg <= cfg_data[vvp_pkg::DIM_W-1:0];
                vvp_pkg::IDX_NEAR:   near_reg   <= cfg_data[vvp_pkg::NEAR_W-1:0];
                vvp_pkg::IDX_PERSP:  persp_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign min_dim  = (width_reg < height_reg) ? width_reg : height_reg;
    assign scale    = min_dim[vvp_pkg::DIM_W-1:1];

    vvp_affine u_affine (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .vert_x   (vert_x),
        .vert_y   (vert_y),
        .vert_z   (vert_z),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .scale    (scale),
        .v_valid  (v_valid),
        .vx       (vx),
        .vy       (vy),
        .vz       (vz)
    );

    // numerators |v| * near + z/2 for round-half-away division
    always_comb
    begin
        z_pos   = (vz > 0);
        mag_x   = vx[vvp_pkg::V_W-1] ? vvp_pkg::MAG_W'(-vx) : vvp_pkg::MAG_W'(vx);
        mag_y   = vy[vvp_pkg::V_W-1] ? vvp_pkg::MAG_W'(-vy) : vvp_pkg::MAG_W'(vy);
        e_numx_next = vvp_pkg::NUM_W'(mag_x * near_reg)
                    + vvp_pkg::NUM_W'(vz[vvp_pkg::V_W-2:1]);
        e_numy_next = vvp_pkg::NUM_W'(mag_y * near_reg)
                    + vvp_pkg::NUM_W'(vz[vvp_pkg::V_W-2:1]);
        e_side_next.vx     = vx;
        e_side_next.vy     = vy;
        e_side_next.vz     = vz;
        e_side_next.neg_x  = vx[vvp_pkg::V_W-1];
        e_side_next.neg_y  = vy[vvp_pkg::V_W-1];
        e_side_next.div_en = persp_reg && z_pos;
        e_side_next.bad    = persp_reg && !z_pos;
        e_den_next = (persp_reg && z_pos) ? vz[vvp_pkg::DEN_W-1:0]
                                          : vvp_pkg::DEN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (adv)
            e_valid_reg <= v_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_numx_reg <= e_numx_next;
            e_numy_reg <= e_numy_next;
            e_den_reg  <= e_den_next;
            e_side_reg <= e_side_next;
        end
    end

    vvp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e_valid_reg),
        .num_x     (e_numx_reg),
        .num_y     (e_numy_reg),
        .den       (e_den_reg),
        .side_in   (e_side_reg),
        .out_valid (q_valid),
        .q_x       (q_x),
        .q_y       (q_y),
        .side_out  (q_side)
    );

    always_comb
    begin
        if (q_side.div_en)
        begin
            rx = q_side.neg_x ? -$signed({2'b00, q_x}) : $signed({2'b00, q_x});
            ry = q_side.neg_y ? -$signed({2'b00, q_y}) : $signed({2'b00, q_y});
        end
        else
        begin
            rx = vvp_pkg::RES_W'(q_side.vx);
            ry = vvp_pkg::RES_W'(q_side.vy);
        end
        rx = rx + $signed({{(vvp_pkg::RES_W - vvp_pkg::DIM_W - 3){1'b0}},
                           width_reg[vvp_pkg::DIM_W-1:1], 4'b0000});
        ry = ry + $signed({{(vvp_pkg::RES_W - vvp_pkg::DIM_W - 3){1'b0}},
                           height_reg[vvp_pkg::DIM_W-1:1], 4'b0000});
        rz = vvp_pkg::RES_W'(q_side.vz);
        sx_next = sat(rx);
        sy_next = sat(ry);
        sz_next = sat(rz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            bad_reg <= q_side.bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign view_depth    = sz_reg;
    assign depth_invalid = bad_reg;

endmodule

FILE: rtl/vvp_affine.sv
module vvp_affine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [vvp_pkg::VERT_W-1:0]   vert_x,
    input  logic signed [vvp_pkg::VERT_W-1:0]   vert_y,
    input  logic signed [vvp_pkg::VERT_W-1:0]   vert_z,
    input  logic [vvp_pkg::CFG_W-1:0]           row_x,
    input  logic [vvp_pkg::CFG_W-1:0]           row_y,
    input  logic [vvp_pkg::CFG_W-1:0]           row_z,
    input  logic [vvp_pkg::S_W-1:0]             scale,
    output logic                                v_valid,
    output logic signed [vvp_pkg::V_W-1:0]      vx,
    output logic signed [vvp_pkg::V_W-1:0]      vy,
    output logic signed [vvp_pkg::V_W-1:0]      vz
);

    logic [vvp_pkg::CFG_W-1:0] rows [3];

    logic                                a_valid_reg;
    logic signed [vvp_pkg::VERT_W-1:0]   a_v_reg [3];
    logic                                b_valid_reg;
    logic signed [vvp_pkg::P_W-1:0]      b_p_reg [3];
    logic signed [vvp_pkg::P_W-1:0]      b_p_next [3];
    logic                                c_valid_reg;
    logic signed [vvp_pkg::PROD_W-1:0]   c_prod_reg [3][3];
    logic signed [vvp_pkg::PROD_W-1:0]   c_prod_next [3][3];
    logic signed [vvp_pkg::COEF_W-1:0]   c_trans_reg [3];
    logic                                d_valid_reg;
    logic signed [vvp_pkg::V_W-1:0]      d_v_reg [3];
    logic signed [vvp_pkg::V_W-1:0]      d_v_next [3];
    logic signed [vvp_pkg::ACC_W-1:0]    acc [3];

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_p_next[i] = vvp_pkg::P_W'(a_v_reg[i] * $signed({1'b0, scale}));
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_prod_next[r][k] = vvp_pkg::PROD_W'(
                    $signed(rows[r][vvp_pkg::COEF_W*k +: vvp_pkg::COEF_W]) * b_p_reg[k]);
            end
        end
        // round half up, then floor by arithmetic shift
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = vvp_pkg::ACC_W'(c_prod_reg[r][0]) + vvp_pkg::ACC_W'(c_prod_reg[r][1])
                   + vvp_pkg::ACC_W'(c_prod_reg[r][2])
                   + (vvp_pkg::ACC_W'(c_trans_reg[r]) <<< vvp_pkg::FRAC_SH)
                   + (vvp_pkg::ACC_W'(1) <<< (vvp_pkg::FRAC_SH - 1));
            d_v_next[r] = vvp_pkg::V_W'(acc[r] >>> vvp_pkg::FRAC_SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_v_reg[0] <= vert_x;
            a_v_reg[1] <= vert_y;
            a_v_reg[2] <= vert_z;
            for (int i = 0; i < 3; i++)
            begin
                b_p_reg[i] <= b_p_next[i];
                d_v_reg[i] <= d_v_next[i];
                c_trans_reg[i] <= $signed(rows[i][vvp_pkg::CFG_W-1 -: vvp_pkg::COEF_W]);
                for (int k = 0; k < 3; k++)
                begin
                    c_prod_reg[i][k] <= c_prod_next[i][k];
                end
            end
        end
    end

    assign v_valid = d_valid_reg;
    assign vx      = d_v_reg[0];
    assign vy      = d_v_reg[1];
    assign vz      = d_v_reg[2];

endmodule

FILE: rtl/vvp_div.sv
module vvp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [vvp_pkg::NUM_W-1:0]     num_x,
    input  logic [vvp_pkg::NUM_W-1:0]     num_y,
    input  logic [vvp_pkg::DEN_W-1:0]     den,
    input  vvp_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [vvp_pkg::NUM_W-1:0]     q_x,
    output logic [vvp_pkg::NUM_W-1:0]     q_y,
    output vvp_pkg::side_t                side_out
);

    localparam int ST_W = vvp_pkg::DEN_W + vvp_pkg::NUM_W;
    localparam int NS   = vvp_pkg::NUM_W;

    // one quotient bit per stage; remainder in the upper part, quotient shifts in below
    function automatic logic [ST_W-1:0] div_step(input logic [ST_W-1:0] st,
                                                 input logic [vvp_pkg::DEN_W-1:0] d);
        logic [vvp_pkg::DEN_W:0] sh;
        logic [vvp_pkg::DEN_W:0] diff;
        sh   = st[ST_W-1:vvp_pkg::NUM_W-1];
        diff = sh - {1'b0, d};
        if (!diff[vvp_pkg::DEN_W])
            return {diff[vvp_pkg::DEN_W-1:0], st[vvp_pkg::NUM_W-2:0], 1'b1};
        else
            return {sh[vvp_pkg::DEN_W-1:0], st[vvp_pkg::NUM_W-2:0], 1'b0};
    endfunction

    logic                          valid_reg [NS];
    logic [ST_W-1:0]               stx_reg   [NS];
    logic [ST_W-1:0]               sty_reg   [NS];
    logic [vvp_pkg::DEN_W-1:0]     den_reg   [NS];
    vvp_pkg::side_t                side_reg  [NS];
    logic [ST_W-1:0]               stx_next  [NS];
    logic [ST_W-1:0]               sty_next  [NS];

    always_comb
    begin
        stx_next[0] = div_step({{vvp_pkg::DEN_W{1'b0}}, num_x}, den);
        sty_next[0] = div_step({{vvp_pkg::DEN_W{1'b0}}, num_y}, den);
        for (int k = 1; k < NS; k++)
        begin
            stx_next[k] = div_step(stx_reg[k-1], den_reg[k-1]);
            sty_next[k] = div_step(sty_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 1; k < NS; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < NS; k++)
            begin
                stx_reg[k] <= stx_next[k];
                sty_reg[k] <= sty_next[k];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign q_x       = stx_reg[NS-1][vvp_pkg::NUM_W-1:0];
    assign q_y       = sty_reg[NS-1][vvp_pkg::NUM_W-1:0];
    assign side_out  = side_reg[NS-1];

endmodule

FILE: rtl/vvp_checker.sv
module vvp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [vvp_pkg::OUT_W-1:0]   screen_x,
    input logic signed [vvp_pkg::OUT_W-1:0]   screen_y,
    input logic signed [vvp_pkg::OUT_W-1:0]   view_depth,
    input logic                               depth_invalid
);

    // held result must not move while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y)
            && $stable(view_depth) && $stable(depth_invalid))
        else $error("result changed under stall");

    // input only backs up when a result is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // nothing valid once reset has been seen at an edge
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // pipeline keeps flowing when output is free
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with free output");

endmodule

bind vertex_view_projection_transform vvp_checker u_vvp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .view_depth    (view_depth),
    .depth_invalid (depth_invalid)
);

FILE: sim/vvp_checker.sv
`timescale 1ns / 1ps

module vvp_scoreboard
    import vvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [VERT_W-1:0] vert_x,
    input  logic signed [VERT_W-1:0] vert_y,
    input  logic signed [VERT_W-1:0] vert_z,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [OUT_W-1:0]  screen_x,
    input  logic signed [OUT_W-1:0]  screen_y,
    input  logic signed [OUT_W-1:0]  view_depth,
    input  logic                     depth_invalid,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic [OUT_W-1:0] depth;
        logic             bad;
    } screen_vertex_t;

    screen_vertex_t   screen_q[$];
    logic [CFG_W-1:0] row_x, row_y, row_z;
    logic [DIM_W-1:0] width, height;
    logic [NEAR_W-1:0] near;
    logic             persp;

    assign pending = screen_q.size();

    function automatic longint coef(logic [CFG_W-1:0] row, int lane);
        logic [15:0] f;
        begin
            f = row[lane*16 +: 16];
            return longint'($signed(f));
        end
    endfunction

    // exact sum in Q.28, round half up to Q.4
    function automatic longint view_coord(logic [CFG_W-1:0] row, longint px, longint py,
                                          longint pz);
        longint acc;
        begin
            acc = coef(row, 0) * px + coef(row, 1) * py + coef(row, 2) * pz
                + (coef(row, 3) <<< 24);
            return (acc + (longint'(1) <<< 23)) >>> 24;
        end
    endfunction

    function automatic longint project(longint c, longint z);
        longint mag, q;
        begin
            mag = (c < 0) ? -c : c;
            q = (mag * longint'(near) + (z >>> 1)) / z;
            return (c < 0) ? -q : q;
        end
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(longint v);
        begin
            if (v > 524287)
                v = 524287;
            if (v < -524288)
                v = -524288;
            return v[OUT_W-1:0];
        end
    endfunction

    function automatic screen_vertex_t transform(logic signed [VERT_W-1:0] x,
                                                 logic signed [VERT_W-1:0] y,
                                                 logic signed [VERT_W-1:0] z);
        screen_vertex_t r;
        longint s, px, py, pz, vx, vy, vz;
        begin
            s  = longint'(((width < height) ? width : height) >> 1);
            px = longint'(x) * s;
            py = longint'(y) * s;
            pz = longint'(z) * s;
            vx = view_coord(row_x, px, py, pz);
            vy = view_coord(row_y, px, py, pz);
            vz = view_coord(row_z, px, py, pz);
            r.bad = 1'b0;
            if (persp) begin
                if (vz > 0) begin
                    vx = project(vx, vz);
                    vy = project(vy, vz);
                end
                else
                    r.bad = 1'b1;
            end
            vx = vx + longint'(width >> 1) * 16;
            vy = vy + longint'(height >> 1) * 16;
            r.sx = clamp_out(vx);
            r.sy = clamp_out(vy);
            r.depth = clamp_out(vz);
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        begin
            $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_x  <= '0;
            row_y  <= '0;
            row_z  <= '0;
            width  <= RST_WIDTH;
            height <= RST_HEIGHT;
            near   <= RST_NEAR;
            persp  <= 1'b0;
            screen_q.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    IDX_ROW_X:  row_x  <= cfg_data;
                    IDX_ROW_Y:  row_y  <= cfg_data;
                    IDX_ROW_Z:  row_z  <= cfg_data;
                    IDX_WIDTH:  width  <= cfg_data[DIM_W-1:0];
                    IDX_HEIGHT: height <= cfg_data[DIM_W-1:0];
                    IDX_NEAR:   near   <= cfg_data[NEAR_W-1:0];
                    IDX_PERSP:  persp  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                screen_q.insert(screen_q.size(), transform(vert_x, vert_y, vert_z));
            if (out_valid && !out_stall) begin
                if (screen_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", screen_x, '0);
                end
                else begin
                    screen_vertex_t e;
                    e = screen_q.pop_front();
                    if (screen_x !== e.sx)
                        report_mismatch("screen_x", screen_x, e.sx);
                    if (screen_y !== e.sy)
                        report_mismatch("screen_y", screen_y, e.sy);
                    if (view_depth !== e.depth)
                        report_mismatch("view_depth", view_depth, e.depth);
                    if (depth_invalid !== e.bad)
                        report_mismatch("depth_invalid", OUT_W'(depth_invalid), OUT_W'(e.bad));
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import vvp_pkg::*;

    localparam logic [IDX_W-1:0] IDX_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [VERT_W-1:0] vert_x = '0, vert_y = '0, vert_z = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [OUT_W-1:0]  screen_x, screen_y, view_depth;
    logic                     depth_invalid;
    logic                     cfg_we = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    int                       fail_count, pending;
    int                       in_idle = 0, out_idle = 0;
    int                       cycles = 0;

    vertex_view_projection_transform i_dut (.*);

    vvp_scoreboard i_checker (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(0, 99) < out_idle);
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    task automatic send_vertex(logic [VERT_W-1:0] x, logic [VERT_W-1:0] y,
                               logic [VERT_W-1:0] z);
        logic taken;
        begin
            while ($urandom_range(0, 99) < in_idle) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            vert_x   <= x;
            vert_y   <= y;
            vert_z   <= z;
            taken = 1'b0;
            while (!taken) begin
                @(negedge clk);
                taken = !in_stall;
                @(posedge clk);
            end
        end
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain;
        begin
            in_valid <= 1'b0;
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    function automatic logic [VERT_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return VERT_W'($urandom);
            1:       return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
            default: return VERT_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // z_ahead keeps view depth positive for most vertices in perspective mode
    function automatic logic [CFG_W-1:0] rand_row(bit z_ahead);
        logic [15:0] t;
        begin
            t = z_ahead ? 16'($urandom_range(4000, 30000)) : 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                return {$urandom, $urandom};
            return {t, rand_coef(), rand_coef(), rand_coef()};
        end
    endfunction

    task automatic setup_view(bit persp, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              logic [CFG_W-1:0] nr);
        begin
            write_reg(IDX_ROW_X, rand_row(1'b0));
            write_reg(IDX_ROW_Y, rand_row(1'b0));
            write_reg(IDX_ROW_Z, rand_row(persp));
            write_reg(IDX_WIDTH, w);
            write_reg(IDX_HEIGHT, h);
            write_reg(IDX_NEAR, nr);
            write_reg(IDX_PERSP, {$urandom, 31'd0, persp});
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] w, h, nr;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        in_idle  = 19;
        out_idle = 45;

        // reset defaults: zero matrix puts everything at the centre
        send_vertex(16'sd16384, -16'sd16384, 16'sd0);
        drain();

        write_reg(IDX_ROW_X, {16'sd80, 16'sd0, 16'sd0, 16'sd16384});
        write_reg(IDX_ROW_Y, {-16'sd32, 16'sd0, 16'sd16384, 16'sd0});
        write_reg(IDX_ROW_Z, {16'sd160, 16'sd16384, 16'sd0, 16'sd0});
        write_reg(IDX_SPARE, '1);
        write_reg(IDX_WIDTH, 64'hFFFF_FFFF_FFFF_F320);
        write_reg(IDX_PERSP, 64'd1);
        send_vertex(16'sd16384, 16'sd16384, 16'sd16384);
        send_vertex(-16'sd16384, -16'sd16384, -16'sd16384);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_vertex(16'sd1, -16'sd1, 16'sd0);
        send_vertex(16'sd0, 16'sd0, -16'sd160);
        send_vertex(16'sd300, -16'sd300, 16'sd5);
        drain();

        // degenerate sizes, near plane zero and maximal
        write_reg(IDX_NEAR, 64'd0);
        send_vertex(16'sd8000, -16'sd8000, 16'sd4000);
        drain();
        write_reg(IDX_WIDTH, 64'd0);
        send_vertex(16'sd16384, 16'sd16384, 16'sd16384);
        drain();
        write_reg(IDX_WIDTH, 64'd4095);
        write_reg(IDX_HEIGHT, 64'd4095);
        write_reg(IDX_NEAR, 64'd65535);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sd1, 16'sd1, 16'sd1);
        drain();
        write_reg(IDX_HEIGHT, 64'd1);
        send_vertex(16'sd16384, -16'sd16384, 16'sd16384);
        drain();
        write_reg(IDX_ROW_X, {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        write_reg(IDX_ROW_Y, {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        write_reg(IDX_HEIGHT, 64'd4095);
        write_reg(IDX_PERSP, 64'd0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sd0);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                in_idle  = 45;
                out_idle = 19;
            end
            else if (phase == 8) begin
                in_idle  = 0;
                out_idle = 0;
            end
            case (phase % 4)
                0: begin w = 64'd4095; h = 64'd4095; nr = 64'd65535; end
                1: begin w = 64'd1; h = 64'd0; nr = 64'd0; end
                default: begin
                    w  = {$urandom, $urandom};
                    h  = {$urandom, $urandom};
                    nr = {$urandom, $urandom};
                end
            endcase
            setup_view(phase % 3 != 2, w, h, nr);
            for (int n = 0; n < 78; n++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: vertex_view_projection_transform.f
rtl/vvp_pkg.sv
rtl/vvp_affine.sv
rtl/vvp_div.sv
rtl/vertex_view_projection_transform.sv
rtl/vvp_checker.sv
sim/vvp_checker.sv
sim/tb.sv
